/* hdl/ugs_pkg.sv */
// ugs_pkg: shared types, constants and code-point class functions for the
// UTF-8 grapheme segmenter. No dependencies; imported by every hdl file.
`timescale 1ns / 1ps

package ugs_pkg;

    // Index and field widths (fixed by the interface fields)
    localparam int IDX_W      = 24;
    localparam int CAP_W      = 24;
    localparam int CP_W       = 21;
    localparam int LEN_W      = 3;
    localparam int HELD_W     = 2;

    // Result queue geometry: one item yields at most MAX_RES results
    localparam int MAX_RES    = 4;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam int RES_W      = $clog2(MAX_RES + 1);

    localparam logic [CAP_W-1:0] CAP_RESET   = '1;
    localparam logic [CP_W-1:0]  REPLACEMENT = 21'h00FFFD;
    localparam logic [CP_W-1:0]  ZWJ         = 21'h00200D;

    // Cluster tracking state, one-hot
    typedef enum logic [2:0] {
        CL_NONE = 3'b001,
        CL_PICT = 3'b010,
        CL_ZWJ  = 3'b100
    } t_cluster;

    // One result as it sits in the output queue
    typedef struct packed {
        logic [IDX_W-1:0] byte_index;
        logic [IDX_W-1:0] codepoint_index;
        logic [IDX_W-1:0] grapheme_index;
        logic [CP_W-1:0]  codepoint_value;
        logic [LEN_W-1:0] sequence_length;
        logic             last_of_run;
    } t_result;

    // Combining marks and variation selectors: attach to the current cluster
    function automatic logic is_mark(input logic [CP_W-1:0] c);
        is_mark = (c >= 21'h000300 && c <= 21'h00036F) ||
                  (c >= 21'h000483 && c <= 21'h000489) ||
                  (c >= 21'h001AB0 && c <= 21'h001AFF) ||
                  (c >= 21'h001DC0 && c <= 21'h001DFF) ||
                  (c >= 21'h0020D0 && c <= 21'h0020FF) ||
                  (c >= 21'h00FE20 && c <= 21'h00FE2F) ||
                  (c >= 21'h00FE00 && c <= 21'h00FE0F);
    endfunction

    // Extended pictographic subset
    function automatic logic is_pict(input logic [CP_W-1:0] c);
        is_pict = (c >= 21'h01F000 && c <= 21'h01FFFF) ||
                  (c == 21'h0000A9) || (c == 21'h0000AE) ||
                  (c >= 21'h002600 && c <= 21'h0027BF);
    endfunction

    // Encoded length announced by a lead byte; zero for ASCII and bad leads
    function automatic logic [LEN_W-1:0] lead_len(input logic [7:0] b);
        if (b[7:5] == 3'b110) begin
            lead_len = 3'd2;
        end else if (b[7:4] == 4'b1110) begin
            lead_len = 3'd3;
        end else if (b[7:3] == 5'b11110) begin
            lead_len = 3'd4;
        end else begin
            lead_len = 3'd0;
        end
    endfunction

endpackage

/* hdl/utf8_grapheme_segmenter.sv */
// utf8_grapheme_segmenter: streaming UTF-8 decoder with grapheme indexing.
// Depends on ugs_pkg (widths, result struct, cluster enum, class functions).
//
//   channel | handshake           | payload
//   --------+---------------------+------------------------------------------
//   in      | i_valid / o_stall   | i_byte_value, i_end_of_text
//   out     | o_valid / i_stall   | o_byte_index .. o_last_of_run
//   cfg     | i_cfg_we            | i_cfg_wdata (source_byte_cap)
//
// One byte is taken per cycle while o_stall is low. A byte is held in the input
// register, then all of its results (zero to four) enter an eight-entry result
// queue at once and leave it one per cycle while i_stall is low. The input
// register waits while the queue holds more than four.
// Reset is synchronous, active low; it empties the queue and restarts text.
// An output stall holds the head result; the input keeps flowing until the
// queue holds more than four results.
`timescale 1ns / 1ps

module utf8_grapheme_segmenter
    import ugs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // input byte channel
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [7:0]       i_byte_value,
    input  logic             i_end_of_text,
    // result channel
    output logic             o_valid,
    input  logic             i_stall,
    output logic [IDX_W-1:0] o_byte_index,
    output logic [IDX_W-1:0] o_codepoint_index,
    output logic [IDX_W-1:0] o_grapheme_index,
    output logic [CP_W-1:0]  o_codepoint_value,
    output logic [LEN_W-1:0] o_sequence_length,
    output logic             o_last_of_run,
    // configuration
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_wdata
);

    // input register
    logic              r_in_vld;
    logic [7:0]        r_in_byte;
    logic              r_in_eot;
    logic              accept;
    logic              adv;

    // decoder and segmenter state
    logic [CAP_W-1:0]  r_cap;
    logic [7:0]        r_hb [3];
    logic [HELD_W-1:0] r_held;
    logic [LEN_W-1:0]  r_exp;
    logic [IDX_W-1:0]  r_bp;
    logic [IDX_W-1:0]  r_cp;
    logic [IDX_W-1:0]  r_gr;
    t_cluster          r_mode;
    logic              r_first;

    logic [HELD_W-1:0] n_held;
    logic [LEN_W-1:0]  n_exp;
    logic [IDX_W-1:0]  n_bp;
    logic [IDX_W-1:0]  n_cp;
    logic [IDX_W-1:0]  n_gr;
    t_cluster          n_mode;
    logic              n_first;

    // step decode
    logic              at_cap;
    logic              flush_after;
    logic [IDX_W-1:0]  bp_inc;
    logic              is_cont;
    logic [LEN_W-1:0]  lead_exp;
    logic [RES_W-1:0]  res_n;
    logic              complete;
    logic              tail_b;
    logic              hb_we;
    logic [HELD_W-1:0] hb_idx;
    logic [CP_W-1:0]   dec_val;
    logic [IDX_W-1:0]  base;

    // cluster decision for a completed multibyte codepoint
    logic [IDX_W-1:0]  cls_gr;
    t_cluster          cls_mode;
    logic              chain;

    // result queue
    t_result           slot [MAX_RES];
    t_result           r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr;
    logic [FIFO_AW-1:0] r_rd;
    logic [CNT_W-1:0]  r_cnt;
    logic              pop;

    // handshakes
    assign pop     = o_valid && !i_stall;
    assign adv     = r_in_vld && (r_cnt <= CNT_W'(FIFO_DEPTH - MAX_RES));
    assign o_stall = r_in_vld && !adv;
    assign accept  = i_valid && !o_stall;

    // hold the incoming byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (accept) begin
            r_in_vld <= 1'b1;
        end else if (adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_byte <= i_byte_value;
            r_in_eot  <= i_end_of_text;
        end
    end

    // capture the byte cap
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_wdata;
        end
    end

    // classify the byte against the held sequence
    assign bp_inc      = r_bp + IDX_W'(1);
    assign at_cap      = (r_bp >= r_cap);
    assign flush_after = r_in_eot || (bp_inc >= r_cap);
    assign is_cont     = (r_in_byte[7:6] == 2'b10);
    assign lead_exp    = lead_len(r_in_byte);
    assign base        = r_bp - IDX_W'(r_held);

    always_comb begin
        res_n    = '0;
        complete = 1'b0;
        tail_b   = 1'b0;
        hb_we    = 1'b0;
        hb_idx   = '0;
        n_held   = r_held;
        n_exp    = r_exp;
        n_bp     = r_bp;
        if (at_cap) begin
            // resolve the held sequence as truncated, drop the byte
            res_n  = RES_W'(r_held);
            n_held = '0;
            n_exp  = '0;
        end else begin
            n_bp = bp_inc;
            if (r_held != '0 && is_cont) begin
                if ({1'b0, r_held} + LEN_W'(1) >= r_exp) begin
                    complete = 1'b1;
                    res_n    = RES_W'(r_exp);
                    n_held   = '0;
                    n_exp    = '0;
                end else begin
                    hb_we  = 1'b1;
                    hb_idx = r_held;
                    if (flush_after) begin
                        res_n  = RES_W'(r_held) + RES_W'(1);
                        n_held = '0;
                        n_exp  = '0;
                    end else begin
                        n_held = r_held + HELD_W'(1);
                    end
                end
            end else begin
                // flush any broken sequence, then take the byte as a lead
                res_n  = RES_W'(r_held);
                n_held = '0;
                n_exp  = '0;
                if (!r_in_byte[7]) begin
                    res_n  = res_n + RES_W'(1);
                    tail_b = 1'b1;
                end else if (lead_exp == '0 || flush_after) begin
                    res_n = res_n + RES_W'(1);
                end else begin
                    hb_we  = 1'b1;
                    n_held = HELD_W'(1);
                    n_exp  = lead_exp;
                end
            end
        end
    end

    // assemble a completed codepoint
    always_comb begin
        case (r_exp)
            3'd2:    dec_val = {10'b0, r_hb[0][4:0], r_in_byte[5:0]};
            3'd3:    dec_val = {5'b0, r_hb[0][3:0], r_hb[1][5:0], r_in_byte[5:0]};
            default: dec_val = {r_hb[0][2:0], r_hb[1][5:0], r_hb[2][5:0], r_in_byte[5:0]};
        endcase
    end

    // decide the grapheme of a completed codepoint
    always_comb begin
        chain    = (r_mode == CL_PICT) || (r_mode == CL_ZWJ);
        cls_gr   = r_gr + IDX_W'(1);
        cls_mode = CL_NONE;
        if (r_first) begin
            cls_gr   = r_gr;
            cls_mode = is_pict(dec_val) ? CL_PICT : CL_NONE;
        end else if (is_mark(dec_val)) begin
            cls_gr   = r_gr;
            cls_mode = r_mode;
        end else if (dec_val == ZWJ) begin
            if (chain) begin
                cls_gr   = r_gr;
                cls_mode = CL_ZWJ;
            end
        end else if (is_pict(dec_val)) begin
            cls_mode = CL_PICT;
            if (r_mode == CL_ZWJ) begin
                cls_gr = r_gr;
            end
        end
    end

    // build the results of this byte
    always_comb begin
        for (int k = 0; k < MAX_RES; k++) begin
            slot[k].byte_index  = base + IDX_W'(k);
            slot[k].last_of_run = (RES_W'(k) + RES_W'(1) == res_n);
            if (complete) begin
                slot[k].codepoint_index = r_cp;
                slot[k].grapheme_index  = cls_gr;
                slot[k].codepoint_value = dec_val;
                slot[k].sequence_length = r_exp;
            end else begin
                slot[k].codepoint_index = r_cp + IDX_W'(k);
                slot[k].grapheme_index  = r_gr + IDX_W'(k) + IDX_W'(!r_first);
                slot[k].codepoint_value = (tail_b && slot[k].last_of_run) ?
                                          {13'b0, r_in_byte} : REPLACEMENT;
                slot[k].sequence_length = LEN_W'(1);
            end
        end
    end

    // advance counters and cluster state; end of text restarts
    always_comb begin
        n_cp    = r_cp;
        n_gr    = r_gr;
        n_mode  = r_mode;
        n_first = r_first;
        if (complete) begin
            n_cp    = r_cp + IDX_W'(1);
            n_gr    = cls_gr;
            n_mode  = cls_mode;
            n_first = 1'b0;
        end else if (res_n != '0) begin
            n_cp    = r_cp + IDX_W'(res_n);
            n_gr    = r_gr + IDX_W'(res_n) - IDX_W'(r_first);
            n_mode  = CL_NONE;
            n_first = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= '0;
            r_exp   <= '0;
            r_bp    <= '0;
            r_cp    <= '0;
            r_gr    <= '0;
            r_mode  <= CL_NONE;
            r_first <= 1'b1;
        end else if (adv) begin
            if (r_in_eot) begin
                r_held  <= '0;
                r_exp   <= '0;
                r_bp    <= '0;
                r_cp    <= '0;
                r_gr    <= '0;
                r_mode  <= CL_NONE;
                r_first <= 1'b1;
            end else begin
                r_held  <= n_held;
                r_exp   <= n_exp;
                r_bp    <= n_bp;
                r_cp    <= n_cp;
                r_gr    <= n_gr;
                r_mode  <= n_mode;
                r_first <= n_first;
            end
        end
    end

    // store the held sequence bytes
    always_ff @(posedge i_clk) begin
        if (adv && hb_we) begin
            r_hb[hb_idx] <= r_in_byte;
        end
    end

    // push results, pop one per cycle while not stalled
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RES; k++) begin
            if (adv && RES_W'(k) < res_n) begin
                r_fifo[r_wr + FIFO_AW'(k)] <= slot[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (adv) begin
                r_wr <= r_wr + FIFO_AW'(res_n);
            end
            if (pop) begin
                r_rd <= r_rd + FIFO_AW'(1);
            end
            r_cnt <= r_cnt + (adv ? CNT_W'(res_n) : CNT_W'(0)) - CNT_W'(pop);
        end
    end

    // drive the head result
    assign o_valid           = (r_cnt != '0);
    assign o_byte_index      = r_fifo[r_rd].byte_index;
    assign o_codepoint_index = r_fifo[r_rd].codepoint_index;
    assign o_grapheme_index  = r_fifo[r_rd].grapheme_index;
    assign o_codepoint_value = r_fifo[r_rd].codepoint_value;
    assign o_sequence_length = r_fifo[r_rd].sequence_length;
    assign o_last_of_run     = r_fifo[r_rd].last_of_run;

endmodule

/* hdl/ugs_check.sv */
// ugs_check: port-level checks for the UTF-8 grapheme segmenter, bound to it.
// Depends on ugs_pkg and on the utf8_grapheme_segmenter port list.
`timescale 1ns / 1ps

module ugs_check
    import ugs_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_valid,
    input logic             i_stall,
    input logic [IDX_W-1:0] o_byte_index,
    input logic [IDX_W-1:0] o_codepoint_index,
    input logic [CP_W-1:0]  o_codepoint_value,
    input logic [LEN_W-1:0] o_sequence_length,
    input logic             o_last_of_run
);

    // hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_byte_index) &&
            $stable(o_codepoint_value) && $stable(o_last_of_run))
        else $error("stalled result changed");

    // a run is queued whole: its next result follows on consecutive bytes
    a_run_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last_of_run |=>
            o_valid && o_byte_index == IDX_W'($past(o_byte_index) + IDX_W'(1)))
        else $error("run broken or byte index skipped");

    // within a run the codepoint index stays or steps by one
    a_run_cp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last_of_run |=>
            o_codepoint_index == $past(o_codepoint_index) ||
            o_codepoint_index == IDX_W'($past(o_codepoint_index) + IDX_W'(1)))
        else $error("codepoint index jumped inside a run");

    // encoding length is one to four
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_sequence_length >= LEN_W'(1) && o_sequence_length <= LEN_W'(4))
        else $error("sequence length out of range");

    // reset drops all queued results
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result shown right after reset");

endmodule

bind utf8_grapheme_segmenter ugs_check u_ugs_check (.*);
